// File: rtl/lccr_pkg.sv
// ----------------------------------------------------------------------------
// lccr_pkg
// Shared codes and constants of the load cell response curve unit.
// ----------------------------------------------------------------------------
package lccr_pkg;

    // Configuration register index codes
    localparam logic [1:0] CFG_RANGE_LOW      = 2'd0;
    localparam logic [1:0] CFG_RANGE_HIGH     = 2'd1;
    localparam logic [1:0] CFG_CURVE_MODE     = 2'd2;
    localparam logic [1:0] CFG_CURVE_EXPONENT = 2'd3;

    // Curve modes; any other code is linear
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_POWER  = 2'd1;
    localparam logic [1:0] MODE_SCURVE = 2'd2;

    localparam int RAW_W  = 24;   // sample and range width
    localparam int GAM_W  = 16;   // exponent width, Q4.12
    localparam int Q30_W  = 30;   // log / exp fraction width
    localparam int POS_W  = 5;    // leading-one position
    localparam int EXP_W  = 39;   // scaled log, Q30 with integer part
    localparam int SAT_N  = 40;   // integer part that underflows to zero

    // Truncating integer square root, 64 bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rb;
        logic [63:0] vv;
        res = '0;
        rb  = 64'h4000_0000_0000_0000;
        vv  = v;
        for (int k = 0; k < 32; k++) begin
            if (vv >= res + rb) begin
                vv  = vv - (res + rb);
                res = (res >> 1) + rb;
            end else begin
                res = res >> 1;
            end
            rb = rb >> 2;
        end
        return res;
    endfunction

    // Q30 factor 2^(-2^-j), j = 1..30, built by a chain of square roots
    function automatic logic [29:0] exp_factor(input int j);
        logic [63:0] d;
        d = isqrt64(64'd1 << 59);
        for (int k = 1; k < j; k++) begin
            d = isqrt64(d << 30);
        end
        return d[29:0];
    endfunction

endpackage

// File: rtl/load_cell_response_curve_unit.sv
// ----------------------------------------------------------------------------
// load_cell_response_curve_unit
// Maps a signed load-cell sample onto the axis range through a linear,
// power or S-shaped response curve.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  sample   | in        | i_in_valid / o_in_ready   | i_raw_sample[23:0] signed
//  result   | out       | o_out_valid / i_out_ready | o_axis_value[15:0]
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index[1:0], i_cfg_data
//
//  One sample per cycle sustained while results are taken; the pipe holds
//  the divider (one quotient bit per stage), the 30 log squaring stages
//  and the 30 exp product stages.
//  All stages move together; when the output register holds an untaken
//  result the whole pipe holds, so nothing is lost or repeated.
//  Reset (synchronous, active low) clears all valid bits and the config registers
//  to their defaults; the config port is always ready.
//
module load_cell_response_curve_unit #(
    parameter int AXIS_MAX  = 65535,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [23:0] i_raw_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_axis_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int F = FRAC_BITS;
    localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};
    localparam int NSQ = lccr_pkg::Q30_W;

    typedef struct packed {
        logic [F:0] t;    // normalized travel
        logic       lo;   // lower S-curve half
        logic       xz;   // power base is zero
    } t_side;

    // ---------------- configuration registers ----------------
    logic [23:0] r_range_low, r_range_high;
    logic [1:0]  r_curve_mode;
    logic [15:0] r_curve_exponent;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low      <= '0;
            r_range_high     <= 24'h7F_FFFF;
            r_curve_mode     <= lccr_pkg::MODE_LINEAR;
            r_curve_exponent <= 16'd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lccr_pkg::CFG_RANGE_LOW:      r_range_low      <= i_cfg_data;
                lccr_pkg::CFG_RANGE_HIGH:     r_range_high     <= i_cfg_data;
                lccr_pkg::CFG_CURVE_MODE:     r_curve_mode     <= i_cfg_data[1:0];
                lccr_pkg::CFG_CURVE_EXPONENT: r_curve_exponent <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipe moves unless a result is stuck at the output
    logic w_adv;
    logic r_out_valid;
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------- normalize: differences ----------------
    logic               r_v1;
    logic signed [24:0] r_num1, r_span1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= i_in_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num1  <= $signed({i_raw_sample[23], i_raw_sample})
                     - $signed({r_range_low[23], r_range_low});
            r_span1 <= $signed({r_range_high[23], r_range_high})
                     - $signed({r_range_low[23], r_range_low});
        end
    end

    // ---------------- normalize: fold reversed range ----------------
    logic               r_v2;
    logic signed [24:0] r_num2, r_span2;
    logic               r_zspan2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_adv) r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zspan2 <= (r_span1 == '0);
            if (r_span1[24]) begin
                r_num2  <= -r_num1;
                r_span2 <= -r_span1;
            end else begin
                r_num2  <= r_num1;
                r_span2 <= r_span1;
            end
        end
    end

    // ---------------- divider: (num*ONE + span/2) / span ----------------
    logic        r_dv   [0:F];
    logic [23:0] r_rem  [0:F];
    logic [F-1:0] r_low [0:F];
    logic [23:0] r_dspan[0:F];
    logic [F-1:0] r_q   [0:F];
    logic        r_zero [0:F];
    logic        r_one  [0:F];

    logic [F+24:0] w_dvd;
    assign w_dvd = {1'b0, r_num2[23:0], {F{1'b0}}} + (F+25)'(r_span2[23:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (w_adv) r_dv[0] <= r_v2;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zero[0]  <= r_zspan2 || r_num2[24] || (r_num2 == '0);
            // rounding can carry the quotient up to exactly ONE
            r_one[0]   <= (r_num2 >= r_span2) || (w_dvd[F+23:F] >= r_span2[23:0]);
            r_rem[0]   <= w_dvd[F+23:F];
            r_low[0]   <= w_dvd[F-1:0];
            r_dspan[0] <= r_span2[23:0];
            r_q[0]     <= '0;
        end
    end

    for (genvar k = 0; k < F; k++) begin : g_div
        logic [24:0] w_cand;
        logic        w_ge;
        logic [24:0] w_diff;
        assign w_cand = {r_rem[k], r_low[k][F-1-k]};
        assign w_ge   = (w_cand >= {1'b0, r_dspan[k]});
        assign w_diff = w_cand - {1'b0, r_dspan[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[k+1] <= 1'b0;
            else if (w_adv) r_dv[k+1] <= r_dv[k];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[k+1]   <= w_ge ? w_diff[23:0] : w_cand[23:0];
                r_q[k+1]     <= {r_q[k][F-2:0], w_ge};
                r_low[k+1]   <= r_low[k];
                r_dspan[k+1] <= r_dspan[k];
                r_zero[k+1]  <= r_zero[k];
                r_one[k+1]   <= r_one[k];
            end
        end
    end

    // ---------------- travel fraction t ----------------
    logic       r_vt;
    logic [F:0] r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vt <= 1'b0;
        else if (w_adv) r_vt <= r_dv[F];
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_zero[F])     r_t <= '0;
            else if (r_one[F]) r_t <= ONE;
            else               r_t <= {1'b0, r_q[F]};
        end
    end

    // ---------------- power base x ----------------
    logic       r_vx;
    logic [F:0] r_x;
    t_side      r_sdx;
    logic       w_lo;
    logic [F:0] w_omt;
    assign w_lo  = (r_t < HALF);
    assign w_omt = ONE - r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vx <= 1'b0;
        else if (w_adv) r_vx <= r_vt;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sdx.t  <= r_t;
            r_sdx.lo <= w_lo;
            // upper S-curve half has a zero base at full travel
            r_sdx.xz <= (r_curve_mode == lccr_pkg::MODE_SCURVE && !w_lo) ? (r_t == ONE)
                                                                         : (r_t == '0);
            if (r_curve_mode == lccr_pkg::MODE_SCURVE) begin
                r_x <= w_lo ? {r_t[F-1:0], 1'b0} : {w_omt[F-1:0], 1'b0};
            end else begin
                r_x <= r_t;
            end
        end
    end

    // ---------------- leading one ----------------
    logic                      r_vp;
    logic [F:0]                r_xp;
    logic [lccr_pkg::POS_W-1:0] r_p;
    t_side                     r_sdp;
    logic [lccr_pkg::POS_W-1:0] w_p;

    always_comb begin
        w_p = '0;
        for (int b = 0; b <= F; b++) begin
            if (r_x[b]) w_p = lccr_pkg::POS_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vp <= 1'b0;
        else if (w_adv) r_vp <= r_vx;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xp  <= r_x;
            r_p   <= w_p;
            r_sdp <= r_sdx;
        end
    end

    // ---------------- -log2 by repeated squaring ----------------
    logic                       r_sv [0:NSQ];
    logic [30:0]                r_m  [0:NSQ];
    logic [29:0]                r_fr [0:NSQ];
    logic [lccr_pkg::POS_W-1:0] r_ps [0:NSQ];
    t_side                      r_sd [0:NSQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else if (w_adv) r_sv[0] <= r_vp;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // mantissa in [1,2) as Q30
            r_m[0]  <= 31'(r_xp) << (lccr_pkg::POS_W'(30) - r_p);
            r_fr[0] <= '0;
            r_ps[0] <= r_p;
            r_sd[0] <= r_sdp;
        end
    end

    for (genvar i = 0; i < NSQ; i++) begin : g_log
        logic [61:0] w_sq;
        logic [31:0] w_s;
        assign w_sq = 62'(r_m[i]) * 62'(r_m[i]);
        assign w_s  = w_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[i+1] <= 1'b0;
            else if (w_adv) r_sv[i+1] <= r_sv[i];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_m[i+1]  <= w_s[31] ? w_s[31:1] : w_s[30:0];
                r_fr[i+1] <= {r_fr[i][28:0], w_s[31]};
                r_ps[i+1] <= r_ps[i];
                r_sd[i+1] <= r_sd[i];
            end
        end
    end

    // ---------------- L = (F - p) - frac, Q30 ----------------
    logic        r_vl;
    logic [34:0] r_l;
    t_side       r_sdl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vl <= 1'b0;
        else if (w_adv) r_vl <= r_sv[NSQ];
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l   <= {lccr_pkg::POS_W'(F) - r_ps[NSQ], 30'd0} - 35'(r_fr[NSQ]);
            r_sdl <= r_sd[NSQ];
        end
    end

    // ---------------- E = round(L * gamma / 4096) ----------------
    logic                       r_ev [0:NSQ];
    logic [lccr_pkg::EXP_W-1:0] r_e  [0:NSQ];
    logic [30:0]                r_r  [0:NSQ];
    t_side                      r_sde[0:NSQ];
    logic [51:0]                w_lg;

    assign w_lg = 52'(r_l) * 52'(r_curve_exponent) + 52'd2048;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev[0] <= 1'b0;
        else if (w_adv) r_ev[0] <= r_vl;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e[0]   <= w_lg[12 +: lccr_pkg::EXP_W];
            r_r[0]   <= 31'd1 << 30;
            r_sde[0] <= r_sdl;
        end
    end

    // ---------------- 2^-frac(E) as a product of constant factors ----------------
    for (genvar j = 1; j <= NSQ; j++) begin : g_exp
        localparam logic [29:0] D = lccr_pkg::exp_factor(j);
        logic [60:0] w_pr;
        assign w_pr = 61'(r_r[j-1]) * 61'(D) + (61'd1 << 29);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_ev[j] <= 1'b0;
            else if (w_adv) r_ev[j] <= r_ev[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_r[j]   <= r_e[j-1][30-j] ? w_pr[60:30] : r_r[j-1];
                r_e[j]   <= r_e[j-1];
                r_sde[j] <= r_sde[j-1];
            end
        end
    end

    // ---------------- scale by 2^-int(E), round ----------------
    logic       r_vs;
    logic [F:0] r_pw;
    t_side      r_sds;
    logic [8:0] w_n;
    logic       w_big;
    logic [6:0] w_sh;
    logic [63:0] w_wide;
    logic [63:0] w_shr;

    assign w_n    = r_e[NSQ][lccr_pkg::EXP_W-1:30];
    assign w_big  = (w_n >= 9'(lccr_pkg::SAT_N));
    assign w_sh   = 7'(30 - F) + w_n[6:0];
    assign w_wide = 64'(r_r[NSQ]) + (64'd1 << (w_sh - 7'd1));
    assign w_shr  = w_wide >> w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vs <= 1'b0;
        else if (w_adv) r_vs <= r_ev[NSQ];
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sds <= r_sde[NSQ];
            if (r_curve_exponent == '0)          r_pw <= ONE;
            else if (r_sde[NSQ].xz || w_big)     r_pw <= '0;
            else                                 r_pw <= w_shr[F:0];
        end
    end

    // ---------------- curve select ----------------
    logic       r_vf;
    logic [F:0] r_s;
    logic [F+1:0] w_hsum;
    logic [F:0] w_h;
    logic [F:0] w_sel;

    assign w_hsum = {1'b0, r_pw} + (F+2)'(1);
    assign w_h    = w_hsum[F+1:1];

    always_comb begin
        unique case (r_curve_mode)
            lccr_pkg::MODE_POWER:  w_sel = r_pw;
            lccr_pkg::MODE_SCURVE: w_sel = r_sds.lo ? w_h : ONE - w_h;
            default:               w_sel = r_sds.t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vf <= 1'b0;
        else if (w_adv) r_vf <= r_vs;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_s <= (w_sel > ONE) ? ONE : w_sel;
    end

    // ---------------- axis scaling, output register ----------------
    logic [15:0]  r_axis;
    logic [F+16:0] w_ax;
    assign w_ax = (F+17)'(r_s) * (F+17)'(AXIS_MAX) + (F+17)'(HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_adv) r_out_valid <= r_vf;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_axis <= w_ax[F+15:F];
    end

    assign o_out_valid  = r_out_valid;
    assign o_axis_value = r_axis;

endmodule

// File: sim/load_cell_response_curve_unit_tb.sv
// ----------------------------------------------------------------------------
// load_cell_response_curve_unit_tb
// Self-checking bench: drives load-cell samples through several range and
// curve settings, predicts each axis value in fixed point and compares every
// result transfer in order against the predicted one.
// ----------------------------------------------------------------------------

// Expected axis values, oldest first
class axis_scoreboard;
    logic [15:0] pending[$];
    int          errors;
    int          checked;

    function void note_sample(logic [15:0] predicted);
        pending.push_back(predicted);
    endfunction

    function void check_result(logic [15:0] actual);
        logic [15:0] want;
        if (pending.size() == 0) begin
            $error("axis_value: unexpected result %0d", actual);
            errors++;
        end else begin
            want = pending.pop_front();
            checked++;
            if (want !== actual) begin
                $error("axis_value: expected %0d, actual %0d", want, actual);
                errors++;
            end
        end
    endfunction
endclass

module load_cell_response_curve_unit_tb;

    localparam int  AXIS_MAX  = 65535;
    localparam int  FRAC_BITS = 16;
    localparam int  LATENCY   = FRAC_BITS + 72;
    localparam longint ONE    = 64'd1 << FRAC_BITS;
    localparam longint Q30    = 64'd1 << 30;
    localparam longint LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [23:0] i_raw_sample = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_axis_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = lccr_pkg::CFG_RANGE_LOW;
    logic [23:0] i_cfg_data = '0;

    // Shadow copy of the register file
    logic [23:0] lo_reg, hi_reg;
    logic [1:0]  mode_reg;
    logic [15:0] gamma_reg;

    axis_scoreboard sb;
    longint cycles = 0;
    bit     no_idle;      // stretch with back-to-back transfers
    int     n_samples;
    int     n_cfg;

    load_cell_response_curve_unit #(.AXIS_MAX(AXIS_MAX), .FRAC_BITS(FRAC_BITS)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- model
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // -log2(x) in Q30, x in 1..ONE
    function automatic longint unsigned minus_log2(longint unsigned x);
        int p;
        longint unsigned m, fr;
        p = 0;
        fr = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        m = x << (30 - p);
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(FRAC_BITS - p) << 30) - fr;
    endfunction

    function automatic longint unsigned raise_to_gamma(longint unsigned x,
                                                        longint unsigned g);
        longint unsigned e, n, f, r, d, s;
        if (g == 0) return ONE;
        if (x == 0) return 0;
        e = (minus_log2(x) * g + 2048) >> 12;
        n = e >> 30;
        f = e & (Q30 - 1);
        if (n >= 40) return 0;
        r = Q30;
        d = int_sqrt(64'd1 << 59);
        for (int i = 1; i <= 30; i++) begin
            if ((f >> (30 - i)) & 1) r = (r * d + (64'd1 << 29)) >> 30;
            d = int_sqrt(d << 30);
        end
        s = 30 - FRAC_BITS + n;
        return (r + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [15:0] axis_from_sample(logic [23:0] raw);
        longint num, span;
        longint unsigned t, sh;
        num  = longint'($signed(raw)) - longint'($signed(lo_reg));
        span = longint'($signed(hi_reg)) - longint'($signed(lo_reg));
        if (span < 0) begin
            span = -span;
            num = -num;
        end
        if (span == 0 || num <= 0) t = 0;
        else if (num >= span) t = ONE;
        else t = ((longint'(num) << FRAC_BITS) + span / 2) / span;
        if (mode_reg == lccr_pkg::MODE_POWER) sh = raise_to_gamma(t, gamma_reg);
        else if (mode_reg == lccr_pkg::MODE_SCURVE) begin
            if (t < ONE / 2) sh = (raise_to_gamma(2 * t, gamma_reg) + 1) >> 1;
            else sh = ONE - ((raise_to_gamma(2 * (ONE - t), gamma_reg) + 1) >> 1);
        end else sh = t;
        if (sh > ONE) sh = ONE;
        return 16'((sh * AXIS_MAX + ONE / 2) >> FRAC_BITS);
    endfunction

    // -------------------------------------------------------------- drivers
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 14);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lccr_pkg::CFG_RANGE_LOW:  lo_reg    = val;
            lccr_pkg::CFG_RANGE_HIGH: hi_reg    = val;
            lccr_pkg::CFG_CURVE_MODE: mode_reg  = val[1:0];
            default:                  gamma_reg = val[15:0];
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sample transfer; valid stays high across back-to-back items
    task automatic send_sample(logic [23:0] raw);
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_sample <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(axis_from_sample(raw));
        n_samples++;
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_raw();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 24'h800000;
        if (k == 1) return 24'h7FFFFF;
        if (k < 5) return lo_reg + 24'($urandom_range(64)) - 24'd32;
        if (k < 7) return hi_reg + 24'($urandom_range(64)) - 24'd32;
        return 24'($urandom);
    endfunction

    // Result side: random back-pressure, sampled at the rising edge
    always @(negedge i_clk) i_out_ready <= !idle_now();

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_axis_value);

    // -------------------------------------------------------------- sequence
    initial begin
        logic [23:0] directed[$];
        logic [15:0] g;
        sb = new();
        no_idle = 1'b0;
        lo_reg = 24'd0;
        hi_reg = 24'h7FFFFF;
        mode_reg = lccr_pkg::MODE_LINEAR;
        gamma_reg = 16'd4096;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, field extremes, every bit of the sample
        directed = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h400000,
                     24'h555555, 24'hAAAAAA, 24'h000001};
        foreach (directed[i]) send_sample(directed[i]);
        end_burst();
        // Power with gamma 1.0, zero base, zero exponent, max exponent
        write_reg(lccr_pkg::CFG_CURVE_MODE, lccr_pkg::MODE_POWER);
        foreach (directed[i]) send_sample(directed[i]);
        end_burst();
        write_reg(lccr_pkg::CFG_CURVE_EXPONENT, 24'd0);
        send_sample(24'h000000);
        send_sample(24'h100000);
        end_burst();
        write_reg(lccr_pkg::CFG_CURVE_EXPONENT, 24'hFFFF);
        send_sample(24'h000001);
        send_sample(24'h7FFF00);
        end_burst();
        // Zero span, then reversed range, S-curve, then code three
        write_reg(lccr_pkg::CFG_RANGE_LOW, 24'h7FFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
        end_burst();
        write_reg(lccr_pkg::CFG_RANGE_HIGH, 24'h800000);
        write_reg(lccr_pkg::CFG_CURVE_MODE, lccr_pkg::MODE_SCURVE);
        write_reg(lccr_pkg::CFG_CURVE_EXPONENT, 24'd8192);
        send_sample(24'h000000);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        end_burst();
        write_reg(lccr_pkg::CFG_CURVE_MODE, 24'd3);
        send_sample(24'h123456);
        send_sample(24'h800000);
        end_burst();

        // Random phases, each with fresh settings
        for (int ph = 0; ph < 16; ph++) begin
            no_idle = (ph == 5);
            write_reg(lccr_pkg::CFG_RANGE_LOW, ($urandom_range(3) == 0) ? 24'($urandom)
                                     : 24'($urandom_range(40000)) - 24'd20000);
            write_reg(lccr_pkg::CFG_RANGE_HIGH, ($urandom_range(3) == 0) ? 24'($urandom)
                                      : lo_reg + 24'($urandom_range(200000)) - 24'd50000);
            write_reg(lccr_pkg::CFG_CURVE_MODE, 24'(ph % 4));
            case ($urandom_range(3))
                0: g = 16'($urandom);
                1: g = 16'($urandom_range(12288, 1024));
                2: g = 16'($urandom_range(8));
                default: g = 16'hFFFF - 16'($urandom_range(8));
            endcase
            write_reg(lccr_pkg::CFG_CURVE_EXPONENT, {8'd0, g});
            repeat (100) send_sample(pick_raw());
            end_burst();
        end

        no_idle = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        $display("Covered %0d samples and %0d register writes across all curve modes;",
                 n_samples, n_cfg);
        $display("%0d results checked.", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lccr_pkg.sv
rtl/load_cell_response_curve_unit.sv
sim/load_cell_response_curve_unit_tb.sv
